>>> rtl/fnpa_pkg.sv
// ----------------------------------------------------------------------------
// fnpa_pkg
// Shared types and constants for the fixed node pool allocator: the words
// on both channels, the operation and status codes, and the controller states.
// ----------------------------------------------------------------------------
package fnpa_pkg;

	// Default pool size.
	localparam int POOL_NODES_DEF = 256;

	// Widths of the channel fields.
	localparam int IDX_FIELD_W = 8;
	localparam int CNT_FIELD_W = 9;

	// Operation codes.
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Status codes.
	localparam logic STAT_OK    = 1'b0;
	localparam logic STAT_EMPTY = 1'b1;

	// One request word.
	typedef struct packed {
		logic                   opcode;
		logic [IDX_FIELD_W-1:0] node_index;
	} fnpa_in_word_t;

	// One response word.
	typedef struct packed {
		logic                   status;
		logic [IDX_FIELD_W-1:0] granted_index;
		logic [CNT_FIELD_W-1:0] nodes_in_use;
	} fnpa_out_word_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_LOAD
	} fnpa_state_t;

endpackage

>>> rtl/fixed_node_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_node_pool_allocator
// Free list allocator over a pool of equal-size nodes named by index.
// ----------------------------------------------------------------------------
// The free list is a head register plus a next-link memory with one entry per
// node; the value POOL_NODES is the null link. After reset the block chains
// the link memory in ST_INIT (entry i points to i + 1) and takes no request
// during that pass. On a release, the link of the released node is written
// with the current head in the cycle it is accepted. An allocate that finds a
// node passes through ST_LOAD, because the new head is the next link of the
// old head and comes from a synchronous memory read; an allocate on an empty
// pool stays in ST_IDLE. Every request gives one response word, registered on
// the output; a new request is taken in ST_IDLE once the previous response
// has been taken or is being taken in the same cycle.
module fixed_node_pool_allocator
	import fnpa_pkg::*;
#(
	parameter int POOL_NODES = POOL_NODES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fnpa_in_word_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output fnpa_out_word_t out_data
);

	localparam int IDX_W  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int HEAD_W = $clog2(POOL_NODES + 1);
	localparam int CNT_W  = $clog2(POOL_NODES + 1);
	localparam int WIDE_W = (HEAD_W > IDX_FIELD_W) ? HEAD_W : IDX_FIELD_W;
	localparam int CW_W   = (CNT_W > CNT_FIELD_W) ? CNT_W : CNT_FIELD_W;

	// Registers.
	fnpa_state_t    state_q, state_d;
	logic [HEAD_W-1:0] head_q, head_d;
	logic [CNT_W-1:0]  used_q, used_d;
	logic [IDX_W-1:0]  init_q, init_d;
	logic              out_valid_q, out_valid_d;
	fnpa_out_word_t    out_data_q, out_data_d;
	logic [HEAD_W-1:0] rd_data_q;

	// Link memory.
	logic [HEAD_W-1:0] link_mem [POOL_NODES];
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [HEAD_W-1:0] wr_data;
	logic [IDX_W-1:0]  rd_addr;

	// Request decode.
	logic              accept;
	logic              head_null;
	logic [WIDE_W-1:0] rel_wide;
	logic              rel_in_range;
	logic [IDX_W-1:0]  rel_addr;
	logic [WIDE_W-1:0] grant_wide;
	logic [CW_W-1:0]   cnt_wide;

	assign head_null    = head_q >= HEAD_W'(POOL_NODES);
	assign rel_wide     = WIDE_W'(in_data.node_index);
	assign rel_in_range = rel_wide < WIDE_W'(POOL_NODES);
	assign rel_addr     = rel_wide[IDX_W-1:0];
	assign grant_wide   = WIDE_W'(head_q[IDX_W-1:0]);
	assign cnt_wide     = CW_W'(used_d);
	assign rd_addr      = head_q[IDX_W-1:0];

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Next state, list update and response.
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		used_d      = used_q;
		init_d      = init_q;
		out_valid_d = out_valid_q && !out_ready;
		out_data_d  = out_data_q;
		wr_en       = 1'b0;
		wr_addr     = rel_addr;
		wr_data     = head_q;
		unique case (state_q)
			ST_INIT: begin
				// Chain each entry to the one after it.
				wr_en   = 1'b1;
				wr_addr = init_q;
				wr_data = HEAD_W'(init_q) + HEAD_W'(1);
				init_d  = init_q + IDX_W'(1);
				if (init_q == IDX_W'(POOL_NODES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					out_valid_d = 1'b1;
					out_data_d.status        = STAT_OK;
					out_data_d.granted_index = '0;
					if (in_data.opcode == OP_ALLOC) begin
						if (head_null) begin
							out_data_d.status = STAT_EMPTY;
						end else begin
							// New head arrives from the link memory next cycle.
							if (used_q < CNT_W'(POOL_NODES)) begin
								used_d = used_q + CNT_W'(1);
							end
							out_data_d.granted_index = grant_wide[IDX_FIELD_W-1:0];
							state_d = ST_LOAD;
						end
					end else if (rel_in_range) begin
						// Push the released node in front of the head.
						wr_en  = 1'b1;
						head_d = HEAD_W'(rel_addr);
						if (used_q != '0) begin
							used_d = used_q - CNT_W'(1);
						end
					end
					out_data_d.nodes_in_use = cnt_wide[CNT_FIELD_W-1:0];
				end
			end
			ST_LOAD: begin
				head_d  = rd_data_q;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			head_q      <= '0;
			used_q      <= '0;
			init_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			used_q      <= used_d;
			init_q      <= init_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		out_data_q <= out_data_d;
	end

	// Link memory write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[wr_addr] <= wr_data;
		end
	end

	// Link memory read port, registered.
	always_ff @(posedge clk) begin
		rd_data_q <= link_mem[rd_addr];
	end

endmodule

>>> rtl/fnpa_checker.sv
// ----------------------------------------------------------------------------
// fnpa_checker
// Port-level checks for the fixed node pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fnpa_checker
	import fnpa_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input fnpa_in_word_t  in_data,
	input logic           out_valid,
	input logic           out_ready,
	input fnpa_out_word_t out_data
);

	// A stalled response word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response word changed while stalled");

	// Every accepted request answers in the next cycle.
	a_resp_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no response after accepted request");

	// A release never reports an empty pool and grants nothing.
	a_release_ok: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.opcode == OP_RELEASE |=>
			out_data.status == STAT_OK && out_data.granted_index == '0)
		else $error("release gave a bad response");

	// An empty-pool answer grants no node.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_EMPTY |-> out_data.granted_index == '0)
		else $error("empty pool response carries an index");

endmodule

bind fixed_node_pool_allocator fnpa_checker u_fnpa_checker (.*);
